@@ rtl/core/gmd_pkg.sv @@
// Shared types and constants for the Gaussian mixture density unit.
// No dependencies; imported by the top level.
`default_nettype none

package gmd_pkg;

   // log2(e) - 1 in Q32, ln2 in Q32 (used with a 37-bit shift), 1/sqrt(2pi) in Q30
   localparam logic [31:0] LOG2E_FRAC_Q32   = 32'd1901360723;
   localparam logic [31:0] LN2_Q32          = 32'd2977044472;
   localparam logic [31:0] INV_SQRT_2PI_Q30 = 32'd428361012;

   // exact floor division of the small series terms by reciprocal multiply:
   // a3 < 2^21 by 6, a4 < 2^17 by 24, a5 < 2^14 by 120
   localparam logic [31:0] RECIP_6   = 32'd2796203;
   localparam int unsigned SHIFT_6   = 24;
   localparam logic [31:0] RECIP_24  = 32'd174763;
   localparam int unsigned SHIFT_24  = 22;
   localparam logic [31:0] RECIP_120 = 32'd17477;
   localparam int unsigned SHIFT_120 = 21;

   localparam logic [6:0]  DIV_FULL  = 7'd64;

   typedef enum logic [28:0] {
      ST_IDLE   = 29'h0000_0001,
      ST_READ   = 29'h0000_0002,
      ST_FETCH  = 29'h0000_0004,
      ST_SQUARE = 29'h0000_0008,
      ST_XDIV   = 29'h0000_0010,
      ST_DIV    = 29'h0000_0020,
      ST_EXP1   = 29'h0000_0040,
      ST_EXP2   = 29'h0000_0080,
      ST_EXP3   = 29'h0000_0100,
      ST_EXP4   = 29'h0000_0200,
      ST_POW1   = 29'h0000_0400,
      ST_POW2   = 29'h0000_0800,
      ST_POW3   = 29'h0000_1000,
      ST_POW4   = 29'h0000_2000,
      ST_POW5   = 29'h0000_4000,
      ST_DIV3   = 29'h0000_8000,
      ST_DIV4   = 29'h0001_0000,
      ST_DIV5   = 29'h0002_0000,
      ST_PSQ    = 29'h0004_0000,
      ST_PSQR   = 29'h0008_0000,
      ST_EFIN   = 29'h0010_0000,
      ST_SQRT   = 29'h0020_0000,
      ST_NUM    = 29'h0040_0000,
      ST_DENS   = 29'h0080_0000,
      ST_WMUL   = 29'h0100_0000,
      ST_ACC    = 29'h0200_0000,
      ST_FINAL  = 29'h0400_0000,
      ST_FDONE  = 29'h0800_0000,
      ST_DONE   = 29'h1000_0000
   } gmd_state_type;

endpackage

`default_nettype wire

@@ rtl/core/gmd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gmd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/core/gaussian_mixture_density_unit.sv @@
// Gaussian mixture density unit: component table, sequencer and shared datapath.
// Depends on gmd_pkg and gmd_ram.
//
//   port group  dir  handshake          carries
//   req_*       in   req_valid/ready    load entry or evaluate observation
//   rsp_*       out  rsp_valid/ready    density, saturated, bad_setup
//   csr_*       in   csr_write_enable   active_components (4 bit)
//
// An evaluation works through each active component, then a final 64-step divide
// (skipped for a bad setup) and wrap-up. All divides use the single shared radix-2
// divider (two 64-step divides per component, none for a zero variance); a component
// with nonzero variance also takes a square root; an underflow skips the power series.
// Synchronous reset clears the sequencer, entry valid bits and the result flag.
// A finished result waits in the output register; loads are taken meanwhile.
`default_nettype none

module gaussian_mixture_density_unit
   import gmd_pkg::*;
#(
   parameter int MAX_COMPONENTS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_mode,
   input  wire logic [2:0]         req_entry_index,
   input  wire logic [15:0]        req_entry_weight,
   input  wire logic signed [23:0] req_entry_mean,
   input  wire logic [23:0]        req_entry_variance,
   input  wire logic signed [23:0] req_observation,
   input  wire logic [23:0]        req_noise_variance,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [31:0]             rsp_density,
   output logic                    rsp_saturated,
   output logic                    rsp_bad_setup,
   input  wire logic               csr_write_enable,
   input  wire logic [3:0]         csr_write_data
);

   localparam int CNT_W  = $clog2(MAX_COMPONENTS + 1);
   localparam int AW     = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
   localparam int WSUM_W = 16 + CNT_W;

   gmd_state_type state_ff, state_in, ret_ff, ret_in;

   logic [3:0]             active_ff, active_in;
   logic [MAX_COMPONENTS-1:0] valid_ff, valid_in;
   logic signed [23:0]     y_ff, y_in;
   logic [23:0]            s2_ff, s2_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in, j_ff, j_in, j_next;
   logic [WSUM_W-1:0]      wsum_ff, wsum_in;
   logic [63:0]            total_ff, total_in;
   logic                   bad_ff, bad_in;
   logic [15:0]            w_ff, w_in;
   logic [24:0]            v_ff, v_in;
   logic [24:0]            ad_ff, ad_in;
   logic [36:0]            x_ff, x_in;
   logic [37:0]            t_ff, t_in;
   logic [5:0]             n_ff, n_in;
   logic [26:0]            a_ff, a_in;
   logic [31:0]            a2_ff, a2_in, a3_ff, a3_in, a4_ff, a4_in, a5_ff, a5_in;
   logic [31:0]            q3_ff, q3_in, q4_ff, q4_in, p_ff, p_in;
   logic [1:0]             k_ff, k_in;
   logic [30:0]            e_ff, e_in;
   logic [57:0]            r_ff, r_in;
   logic [56:0]            b_ff, b_in, vrem_ff, vrem_in;
   logic [63:0]            prod_ff;
   logic [31:0]            mul_a, mul_b;
   logic [63:0]            dvd_ff, dvd_in, dsr_ff, dsr_in, rem_ff, rem_in, quo_ff, quo_in;
   logic [6:0]             dcnt_ff, dcnt_in;
   logic [31:0]            res_density_ff, res_density_in;
   logic                   res_sat_ff, res_sat_in, res_bad_ff, res_bad_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_density_ff, rsp_density_in;
   logic                   rsp_sat_ff, rsp_sat_in, rsp_bad_ff, rsp_bad_in;

   logic                   load_wr;
   logic [AW-1:0]          ram_waddr;
   logic [AW-1:0]          j_addr;
   logic [63:0]            ram_rdata;
   logic signed [24:0]     diff;
   logic [64:0]            div_rem2;
   logic                   div_ge;
   logic [57:0]            sq_rb;
   logic                   sq_ge;
   logic [5:0]             t_int;
   logic [15:0]            fetch_w;
   logic [23:0]            fetch_mean, fetch_var;

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_density   = rsp_density_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_bad_setup = rsp_bad_ff;

   assign load_wr   = req_valid && req_ready && !req_mode
                      && (32'(req_entry_index) < MAX_COMPONENTS);
   assign ram_waddr = AW'(req_entry_index);
   assign j_addr    = j_ff[AW-1:0];

   gmd_ram #(
      .WIDTH (64),
      .DEPTH (MAX_COMPONENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (ram_waddr),
      .wr_data ({req_entry_weight, req_entry_mean, req_entry_variance}),
      .rd_addr (j_addr),
      .rd_data (ram_rdata)
   );

   // never-written entries read as zero
   always_comb begin
      if (valid_ff[j_addr]) begin
         fetch_w    = ram_rdata[63:48];
         fetch_mean = ram_rdata[47:24];
         fetch_var  = ram_rdata[23:0];
      end else begin
         fetch_w    = '0;
         fetch_mean = '0;
         fetch_var  = '0;
      end
   end

   assign diff     = 25'(y_ff) - 25'($signed(fetch_mean));
   assign div_rem2 = {rem_ff, dvd_ff[63]};
   assign div_ge   = div_rem2 >= {1'b0, dsr_ff};
   assign sq_rb    = r_ff + {1'b0, b_ff};
   assign sq_ge    = {1'b0, vrem_ff} >= sq_rb;
   assign t_int    = t_ff[37:32];
   assign j_next   = j_ff + CNT_W'(1);

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQUARE: begin mul_a = 32'(ad_ff);          mul_b = 32'(ad_ff); end
         ST_EXP1:   begin mul_a = 32'(quo_ff[36:16]);  mul_b = LOG2E_FRAC_Q32; end
         ST_EXP2:   begin mul_a = 32'(x_ff[15:0]);     mul_b = LOG2E_FRAC_Q32; end
         ST_EXP4:   begin mul_a = t_ff[31:0];          mul_b = LN2_Q32; end
         ST_POW1:   begin mul_a = 32'(prod_ff[63:37]); mul_b = 32'(prod_ff[63:37]); end
         ST_POW2:   begin mul_a = prod_ff[61:30];      mul_b = 32'(a_ff); end
         ST_POW3:   begin mul_a = prod_ff[61:30];      mul_b = 32'(a_ff); end
         ST_POW4:   begin mul_a = prod_ff[61:30];      mul_b = 32'(a_ff); end
         ST_POW5:   begin mul_a = a3_ff;               mul_b = RECIP_6; end
         ST_DIV3:   begin mul_a = a4_ff;               mul_b = RECIP_24; end
         ST_DIV4:   begin mul_a = a5_ff;               mul_b = RECIP_120; end
         ST_PSQ:    begin mul_a = p_ff;                mul_b = p_ff; end
         ST_NUM:    begin mul_a = 32'(e_ff);           mul_b = INV_SQRT_2PI_Q30; end
         ST_WMUL:   begin mul_a = 32'(w_ff);           mul_b = quo_ff[31:0]; end
         default:   begin mul_a = '0;                  mul_b = '0; end
      endcase
   end

   always_comb begin
      state_in = state_ff;   ret_in = ret_ff;
      active_in = active_ff; valid_in = valid_ff;
      y_in = y_ff; s2_in = s2_ff; cnt_in = cnt_ff; j_in = j_ff;
      wsum_in = wsum_ff; total_in = total_ff; bad_in = bad_ff;
      w_in = w_ff; v_in = v_ff; ad_in = ad_ff; x_in = x_ff; t_in = t_ff; n_in = n_ff;
      a_in = a_ff; a2_in = a2_ff; a3_in = a3_ff; a4_in = a4_ff; a5_in = a5_ff;
      q3_in = q3_ff; q4_in = q4_ff; p_in = p_ff; k_in = k_ff; e_in = e_ff;
      r_in = r_ff; b_in = b_ff; vrem_in = vrem_ff;
      dvd_in = dvd_ff; dsr_in = dsr_ff; rem_in = rem_ff; quo_in = quo_ff; dcnt_in = dcnt_ff;
      res_density_in = res_density_ff; res_sat_in = res_sat_ff; res_bad_in = res_bad_ff;
      rsp_valid_in = rsp_valid_ff; rsp_density_in = rsp_density_ff;
      rsp_sat_in = rsp_sat_ff; rsp_bad_in = rsp_bad_ff;

      if (csr_write_enable) begin
         active_in = csr_write_data;
      end
      if (load_wr) begin
         valid_in[ram_waddr] = 1'b1;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_mode) begin
               y_in     = req_observation;
               s2_in    = req_noise_variance;
               j_in     = '0;
               wsum_in  = '0;
               total_in = '0;
               bad_in   = 1'b0;
               if (active_ff == 4'd0) begin
                  cnt_in = CNT_W'(1);
               end else if (32'(active_ff) > MAX_COMPONENTS) begin
                  cnt_in = CNT_W'(MAX_COMPONENTS);
               end else begin
                  cnt_in = CNT_W'(active_ff);
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            w_in    = fetch_w;
            v_in    = 25'(fetch_var) + 25'(s2_ff);
            ad_in   = diff[24] ? 25'(-diff) : 25'(diff);
            wsum_in = wsum_ff + WSUM_W'(fetch_w);
            if ((25'(fetch_var) + 25'(s2_ff)) == 25'd0) begin
               // zero variance: flag, skip the density
               bad_in = 1'b1;
               j_in   = j_next;
               state_in = (j_next == cnt_ff) ? ST_FINAL : ST_READ;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_XDIV;
         end
         ST_XDIV: begin
            dvd_in = prod_ff << 15;  dsr_in = 64'(v_ff);
            rem_in = '0;  quo_in = '0;  dcnt_in = DIV_FULL;
            ret_in = ST_EXP1;  state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = div_ge ? 64'(div_rem2 - {1'b0, dsr_ff}) : div_rem2[63:0];
            quo_in  = {quo_ff[62:0], div_ge};
            dvd_in  = dvd_ff << 1;
            dcnt_in = dcnt_ff - 7'd1;
            if (dcnt_ff == 7'd1) begin
               state_in = ret_ff;
            end
         end
         ST_EXP1: begin
            if (|quo_ff[63:37]) begin
               // exponent argument at or past 32: term underflows to zero
               e_in = '0;
               vrem_in = {v_ff, 32'b0};  r_in = '0;  b_in = 57'(1) << 56;
               state_in = ST_SQRT;
            end else begin
               x_in = quo_ff[36:0];
               state_in = ST_EXP2;
            end
         end
         ST_EXP2: begin
            t_in = 38'(x_ff) + 38'(prod_ff >> 16);
            state_in = ST_EXP3;
         end
         ST_EXP3: begin
            t_in = t_ff + 38'(prod_ff >> 32);
            state_in = ST_EXP4;
         end
         ST_EXP4: begin
            n_in = t_int;
            if (t_int > 6'd30) begin
               e_in = '0;
               vrem_in = {v_ff, 32'b0};  r_in = '0;  b_in = 57'(1) << 56;
               state_in = ST_SQRT;
            end else begin
               state_in = ST_POW1;
            end
         end
         ST_POW1: begin
            a_in = prod_ff[63:37];
            state_in = ST_POW2;
         end
         ST_POW2: begin
            a2_in = prod_ff[61:30];
            state_in = ST_POW3;
         end
         ST_POW3: begin
            a3_in = prod_ff[61:30];
            state_in = ST_POW4;
         end
         ST_POW4: begin
            a4_in = prod_ff[61:30];
            state_in = ST_POW5;
         end
         ST_POW5: begin
            a5_in    = prod_ff[61:30];
            state_in = ST_DIV3;
         end
         ST_DIV3: begin
            q3_in    = 32'(prod_ff >> SHIFT_6);
            state_in = ST_DIV4;
         end
         ST_DIV4: begin
            q4_in    = 32'(prod_ff >> SHIFT_24);
            state_in = ST_DIV5;
         end
         ST_DIV5: begin
            p_in = (32'd1 << 30) - 32'(a_ff) + (a2_ff >> 1) + q4_ff - q3_ff
                   - 32'(prod_ff >> SHIFT_120);
            k_in = '0;
            state_in = ST_PSQ;
         end
         ST_PSQ: begin
            state_in = ST_PSQR;
         end
         ST_PSQR: begin
            p_in = 32'((prod_ff + (64'd1 << 29)) >> 30);
            k_in = k_ff + 2'd1;
            state_in = (k_ff == 2'd2) ? ST_EFIN : ST_PSQ;
         end
         ST_EFIN: begin
            e_in = 31'(p_ff >> n_ff);
            vrem_in = {v_ff, 32'b0};  r_in = '0;  b_in = 57'(1) << 56;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (b_ff == '0) begin
               state_in = ST_NUM;
            end else begin
               if (sq_ge) begin
                  vrem_in = 57'({1'b0, vrem_ff} - sq_rb);
                  r_in    = (r_ff >> 1) + {1'b0, b_ff};
               end else begin
                  r_in    = r_ff >> 1;
               end
               b_in = b_ff >> 2;
            end
         end
         ST_NUM: begin
            state_in = ST_DENS;
         end
         ST_DENS: begin
            dvd_in = prod_ff + {24'b0, r_ff[28:0], 11'b0};
            dsr_in = {23'b0, r_ff[28:0], 12'b0};
            rem_in = '0;  quo_in = '0;  dcnt_in = DIV_FULL;
            ret_in = ST_WMUL;  state_in = ST_DIV;
         end
         ST_WMUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            total_in = total_ff + prod_ff;
            j_in     = j_next;
            state_in = (j_next == cnt_ff) ? ST_FINAL : ST_READ;
         end
         ST_FINAL: begin
            if (bad_ff || (wsum_ff == '0)) begin
               res_density_in = '1;  res_sat_in = 1'b1;  res_bad_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               dvd_in = total_ff + 64'(wsum_ff >> 1);
               dsr_in = 64'(wsum_ff);
               rem_in = '0;  quo_in = '0;  dcnt_in = DIV_FULL;
               ret_in = ST_FDONE;  state_in = ST_DIV;
            end
         end
         ST_FDONE: begin
            res_sat_in     = |quo_ff[63:32];
            res_density_in = (|quo_ff[63:32]) ? '1 : quo_ff[31:0];
            res_bad_in     = 1'b0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_density_in = res_density_ff;
               rsp_sat_in     = res_sat_ff;
               rsp_bad_in     = res_bad_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         active_ff    <= 4'd1;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         active_ff    <= active_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      y_ff <= y_in;  s2_ff <= s2_in;  cnt_ff <= cnt_in;  j_ff <= j_in;
      wsum_ff <= wsum_in;  total_ff <= total_in;  bad_ff <= bad_in;
      w_ff <= w_in;  v_ff <= v_in;  ad_ff <= ad_in;  x_ff <= x_in;  t_ff <= t_in;
      n_ff <= n_in;  a_ff <= a_in;  a2_ff <= a2_in;  a3_ff <= a3_in;  a4_ff <= a4_in;
      a5_ff <= a5_in;  q3_ff <= q3_in;  q4_ff <= q4_in;  p_ff <= p_in;  k_ff <= k_in;
      e_ff <= e_in;  r_ff <= r_in;  b_ff <= b_in;  vrem_ff <= vrem_in;
      dvd_ff <= dvd_in;  dsr_ff <= dsr_in;  rem_ff <= rem_in;  quo_ff <= quo_in;
      dcnt_ff <= dcnt_in;
      res_density_ff <= res_density_in;  res_sat_ff <= res_sat_in;  res_bad_ff <= res_bad_in;
      rsp_density_ff <= rsp_density_in;  rsp_sat_ff <= rsp_sat_in;  rsp_bad_ff <= rsp_bad_in;
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dcnt_ff != 7'd0))
      else $error("divider running with zero step count");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (j_ff < cnt_ff))
      else $error("component index past active count");

   a_bad_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_sat_ff && (rsp_density_ff == '1)))
      else $error("bad setup result not saturated");

endmodule

`default_nettype wire

@@ tb/sv/gaussian_mixture_density_unit_tb.sv @@
// Self-checking testbench for gaussian_mixture_density_unit.
// Depends on gmd_pkg and the unit's RTL; predicts every density in fixed point.
`timescale 1ns / 100ps
`default_nettype none

module gaussian_mixture_density_unit_tb;
   import gmd_pkg::*;

   localparam int NUM_ENTRIES    = 8;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   typedef struct packed {
      logic [31:0] density;
      logic        saturated;
      logic        bad_setup;
   } density_result_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_mode;
   logic [2:0]         req_entry_index;
   logic [15:0]        req_entry_weight;
   logic signed [23:0] req_entry_mean;
   logic [23:0]        req_entry_variance;
   logic signed [23:0] req_observation;
   logic [23:0]        req_noise_variance;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [31:0]        rsp_density;
   logic               rsp_saturated;
   logic               rsp_bad_setup;
   logic               csr_write_enable;
   logic [3:0]         csr_write_data;

   // Shadow copy of the component table and register
   logic [15:0]        mix_weight [NUM_ENTRIES];
   logic signed [23:0] mix_mean [NUM_ENTRIES];
   logic [23:0]        mix_variance [NUM_ENTRIES];
   logic [3:0]         mix_active;

   density_result_type pending_density [$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  idling_on = 1'b1;
   int  rsp_stall_left = 0;

   gaussian_mixture_density_unit #(.MAX_COMPONENTS(NUM_ENTRIES)) dut (.*);

   always #5 clock = ~clock;

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r, b;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // exp(-x), x in Q32, result in Q30
   function automatic logic [63:0] decay_q30(input logic [63:0] x);
      logic [63:0] t, n, f, a, a2, a3, a4, a5, p;
      t = x + (((x >> 16) * LOG2E_FRAC_Q32) >> 16)
            + (((x & 64'hFFFF) * LOG2E_FRAC_Q32) >> 32);
      n = t >> 32;
      f = t & 64'hFFFF_FFFF;
      if (n > 30) return 64'd0;
      a  = (f * LN2_Q32) >> 37;
      a2 = (a * a) >> 30;
      a3 = (a2 * a) >> 30;
      a4 = (a3 * a) >> 30;
      a5 = (a4 * a) >> 30;
      p = (64'd1 << 30) - a + a2 / 2 + a4 / 24 - a3 / 6 - a5 / 120;
      repeat (3) p = (p * p + (64'd1 << 29)) >> 30;
      return p >> n;
   endfunction

   function automatic density_result_type mixture_density(input logic signed [23:0] y,
                                                          input logic [23:0] s2);
      density_result_type res;
      int count;
      logic [63:0] wsum, total, v, ad, x, e, s, num, den, dens;
      longint d;
      bit bad;
      wsum = 64'd0;
      total = 64'd0;
      bad = 1'b0;
      count = (mix_active == 0) ? 1 : (mix_active > NUM_ENTRIES) ? NUM_ENTRIES : mix_active;
      for (int j = 0; j < count; j++) begin
         v = 64'(mix_variance[j]) + 64'(s2);
         d = longint'(y) - longint'(mix_mean[j]);
         ad = (d < 0) ? -d : d;
         wsum += 64'(mix_weight[j]);
         if (v == 0) begin
            bad = 1'b1;
         end else begin
            x = ((ad * ad) << 15) / v;
            e = (x >= (64'd32 << 32)) ? 64'd0 : decay_q30(x);
            s = root64(v << 32);
            num = e * INV_SQRT_2PI_Q30;
            den = s << 12;
            dens = (num + den / 2) / den;
            total += 64'(mix_weight[j]) * dens;
         end
      end
      if (wsum == 0) bad = 1'b1;
      res.bad_setup = bad;
      if (bad) begin
         res.density = '1;
         res.saturated = 1'b1;
      end else begin
         total = (total + wsum / 2) / wsum;
         res.saturated = (total > 64'hFFFF_FFFF);
         res.density = res.saturated ? 32'hFFFF_FFFF : total[31:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      density_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_density.size() == 0) begin
            report_mismatch("unexpected result", rsp_density, 32'd0);
         end else begin
            want = pending_density.pop_front();
            if (rsp_density !== want.density)
               report_mismatch("density", rsp_density, want.density);
            if (rsp_saturated !== want.saturated)
               report_mismatch("saturated", 32'(rsp_saturated), 32'(want.saturated));
            if (rsp_bad_setup !== want.bad_setup)
               report_mismatch("bad_setup", 32'(rsp_bad_setup), 32'(want.bad_setup));
         end
      end
   end

   // Result-side stalls in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (idling_on && rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_stall_left <= $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request, hold until accepted, then maybe pause the sender
   task automatic send_request(input logic mode, input logic [2:0] index,
                               input logic [15:0] weight, input logic [23:0] mean,
                               input logic [23:0] variance, input logic [23:0] y,
                               input logic [23:0] s2);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_entry_index <= index;
      req_entry_weight <= weight;
      req_entry_mean <= mean;
      req_entry_variance <= variance;
      req_observation <= y;
      req_noise_variance <= s2;
      do @(posedge clock); while (!req_ready);
      if (mode == MODE_LOAD) begin
         mix_weight[index] = weight;
         mix_mean[index] = mean;
         mix_variance[index] = variance;
      end else begin
         pending_density.push_back(mixture_density(y, s2));
      end
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected result has come, then settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_density.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_active(input logic [3:0] count);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mix_active = count;
   endtask

   task automatic load_entry(input logic [2:0] index, input logic [15:0] weight,
                             input logic [23:0] mean, input logic [23:0] variance);
      send_request(MODE_LOAD, index, weight, mean, variance, 24'($urandom), 24'($urandom));
   endtask

   task automatic evaluate(input logic [23:0] y, input logic [23:0] s2);
      send_request(MODE_EVAL, 3'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                   y, s2);
   endtask

   task automatic test_after_reset();
      // empty table: zero weight sum and zero variance
      evaluate(24'h0, 24'h0);
      evaluate(24'h12_3456, 24'h01_0000);
   endtask

   task automatic test_extremes();
      load_entry(3'd0, 16'hFFFF, 24'h7F_FFFF, 24'hFF_FFFF);
      evaluate(24'h7F_FFFF, 24'hFF_FFFF);
      evaluate(24'h80_0000, 24'h0);
      load_entry(3'd0, 16'hFFFF, 24'h0, 24'h00_0001);
      evaluate(24'h0, 24'h0);
      evaluate(24'h00_0001, 24'h0);
      load_entry(3'd0, 16'h0001, 24'h80_0000, 24'h01_0000);
      evaluate(24'h7F_FFFF, 24'h0);
      evaluate(24'h80_0000, 24'h0);
      load_entry(3'd0, 16'h0, 24'h0, 24'h01_0000);
      evaluate(24'h0, 24'h0);
   endtask

   task automatic test_register_and_setup();
      load_entry(3'd0, 16'h8000, 24'h01_0000, 24'h00_8000);
      load_entry(3'd7, 16'h4000, 24'hFF_0000, 24'h02_0000);
      write_active(4'd8);
      evaluate(24'h0, 24'h0);
      evaluate(24'h0, 24'h00_4000);
      write_active(4'd0);
      evaluate(24'h01_0000, 24'h0);
      write_active(4'd15);
      evaluate(24'h0, 24'h01_0000);
      write_active(4'd9);
      evaluate(24'hFF_0000, 24'h0);
      for (int i = 1; i < 7; i++)
         load_entry(i[2:0], 16'($urandom), 24'($urandom_range(0, 24'h3_FFFF)),
                    24'($urandom_range(1, 24'h4_0000)));
      evaluate(24'h0, 24'h0);
      load_entry(3'd3, 16'h1234, 24'h0, 24'h0);
      evaluate(24'h0, 24'h0);
   endtask

   function automatic logic [23:0] random_variance();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'($urandom_range(0, 16));
         default: return 24'($urandom_range(1, 24'h08_0000));
      endcase
   endfunction

   task automatic random_phase(input int items);
      int count;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(0, 99) < 35) begin
            load_entry(3'($urandom), ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom),
                       $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                 : 24'($signed($urandom_range(0, 24'h8_0000)) - 24'h4_0000),
                       random_variance());
         end else begin
            evaluate($urandom_range(0, 3) == 0 ? 24'($urandom)
                                               : 24'($signed($urandom_range(0, 24'h8_0000)) - 24'h4_0000),
                     ($urandom_range(0, 2) == 0) ? 24'h0 : random_variance());
         end
         if (i % 60 == 59) begin
            // mostly small active counts, which keeps evaluations short
            count = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 3);
            write_active(count[3:0]);
         end
      end
   endtask

   task automatic test_random();
      write_active(4'd2);
      random_phase(380);
      write_active(4'd1);
      random_phase(60);
      drain_results();
      idling_on = 1'b0;
      write_active(4'd3);
      random_phase(60);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_LOAD;
      req_entry_index <= '0;
      req_entry_weight <= '0;
      req_entry_mean <= '0;
      req_entry_variance <= '0;
      req_observation <= '0;
      req_noise_variance <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         mix_weight[i] = '0;
         mix_mean[i] = '0;
         mix_variance[i] = '0;
      end
      mix_active = 4'd1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_extremes();
      test_register_and_setup();
      test_random();
      drain_results();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ gaussian_mixture_density_unit.f @@
rtl/core/gmd_pkg.sv
rtl/core/gmd_ram.sv
rtl/core/gaussian_mixture_density_unit.sv
tb/sv/gaussian_mixture_density_unit_tb.sv
